@@ rtl/tksi_pkg.sv @@
// shared types and constants for the top-k sorted insert block
package tksi_pkg;

    localparam int MAX_ENTRIES = 24;
    localparam int IDX_W       = 5;
    localparam int SCORE_W     = 32;
    localparam int TAG_W       = 32;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_CLEAR  = 2'd1,
        CMD_READ   = 2'd2
    } t_cmd;

    typedef struct packed {
        t_cmd                      cmd;
        logic signed [SCORE_W-1:0] item_score;
        logic [TAG_W-1:0]          item_tag;
        logic [IDX_W-1:0]          read_index;
    } t_in_item;

    typedef struct packed {
        logic                      accepted;
        logic [IDX_W-1:0]          insert_position;
        logic [IDX_W-1:0]          entry_count;
        logic                      entry_valid;
        logic signed [SCORE_W-1:0] entry_score;
        logic [TAG_W-1:0]          entry_tag;
    } t_out_item;

    // broadcast from the top level to every cell
    typedef struct packed {
        logic                      insert_en;
        logic signed [SCORE_W-1:0] score;
        logic [TAG_W-1:0]          tag;
    } t_cell_ctrl;

    // status a cell reports back
    typedef struct packed {
        logic ge;
        logic take;
    } t_cell_stat;

endpackage

@@ rtl/tksi_cell.sv @@
// one list slot: compares against the new score, keeps, loads, or takes its upper neighbor
module tksi_cell (
    input  logic                              i_clk,
    input  tksi_pkg::t_cell_ctrl              i_ctrl,
    input  logic                              i_slot_valid,
    input  logic                              i_prev_ge,
    input  logic signed [tksi_pkg::SCORE_W-1:0] i_prev_score,
    input  logic [tksi_pkg::TAG_W-1:0]        i_prev_tag,
    output tksi_pkg::t_cell_stat              o_stat,
    output logic signed [tksi_pkg::SCORE_W-1:0] o_score,
    output logic [tksi_pkg::TAG_W-1:0]        o_tag
);

    logic signed [tksi_pkg::SCORE_W-1:0] r_score;
    logic [tksi_pkg::TAG_W-1:0]          r_tag;
    logic                                w_ge;
    logic                                w_take;

    // equal scores stay above the new item so ties keep arrival order
    assign w_ge   = i_slot_valid && (r_score >= i_ctrl.score);
    assign w_take = i_prev_ge && !w_ge;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.insert_en) begin
            if (w_take) begin
                r_score <= i_ctrl.score;
                r_tag   <= i_ctrl.tag;
            end else if (!i_prev_ge) begin
                r_score <= i_prev_score;
                r_tag   <= i_prev_tag;
            end
        end
    end

    assign o_stat.ge   = w_ge;
    assign o_stat.take = w_take;
    assign o_score     = r_score;
    assign o_tag       = r_tag;

endmodule

@@ rtl/top_k_sorted_insert.sv @@
// top level: chain of sorted cells with command decode and registered result
// Takes one command (insert, clear, read) per clock cycle; busy never rises.
// Each command gives one result, shown with o_done high for exactly one cycle
// on the cycle after the transfer; the receiver cannot stall, so the result
// must be captured then. The insert goes through a row of 24 cells that all
// compare the new score in parallel and shift in the same cycle, so the
// critical path is one 32-bit compare per cell plus the accept decision over
// the row. Writing capacity clears the list and must be done while idle.
module top_k_sorted_insert (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  tksi_pkg::t_in_item     i_item,
    input  logic                   i_cfg_we,
    input  logic [tksi_pkg::IDX_W-1:0] i_cfg_wdata,
    output logic                   o_done,
    output tksi_pkg::t_out_item    o_result
);

    localparam int N = tksi_pkg::MAX_ENTRIES;

    logic [tksi_pkg::IDX_W-1:0] r_cap;
    logic [tksi_pkg::IDX_W-1:0] r_count;
    logic [tksi_pkg::IDX_W-1:0] n_count;
    logic                       r_done;
    tksi_pkg::t_out_item        r_result;
    tksi_pkg::t_out_item        n_result;

    tksi_pkg::t_cell_ctrl       w_ctrl;
    tksi_pkg::t_cell_stat       w_stat [N];
    logic signed [tksi_pkg::SCORE_W-1:0] w_score [N];
    logic [tksi_pkg::TAG_W-1:0] w_tag [N];
    logic [N-1:0]               w_valid;

    logic                       w_fire;
    logic [tksi_pkg::IDX_W-1:0] w_cap;
    logic                       w_full;
    logic                       w_hit;
    logic [tksi_pkg::IDX_W-1:0] w_pos;
    logic                       w_ins_ok;

    assign busy   = 1'b0;
    assign w_fire = start && !busy;
    assign w_cap  = (r_cap > tksi_pkg::IDX_W'(N)) ? tksi_pkg::IDX_W'(N) : r_cap;
    assign w_full = (r_count == w_cap);

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++) begin : g_cell
            assign w_valid[gi] = (tksi_pkg::IDX_W'(gi) < r_count);
            if (gi == 0) begin : g_head
                tksi_cell u_cell (
                    .i_clk        (i_clk),
                    .i_ctrl       (w_ctrl),
                    .i_slot_valid (w_valid[gi]),
                    .i_prev_ge    (1'b1),
                    .i_prev_score (w_ctrl.score),
                    .i_prev_tag   (w_ctrl.tag),
                    .o_stat       (w_stat[gi]),
                    .o_score      (w_score[gi]),
                    .o_tag        (w_tag[gi])
                );
            end else begin : g_body
                tksi_cell u_cell (
                    .i_clk        (i_clk),
                    .i_ctrl       (w_ctrl),
                    .i_slot_valid (w_valid[gi]),
                    .i_prev_ge    (w_stat[gi-1].ge),
                    .i_prev_score (w_score[gi-1]),
                    .i_prev_tag   (w_tag[gi-1]),
                    .o_stat       (w_stat[gi]),
                    .o_score      (w_score[gi]),
                    .o_tag        (w_tag[gi])
                );
            end
        end
    endgenerate

    // ge is a prefix over the row, so at most one cell can take the new item
    always_comb begin
        w_hit = 1'b0;
        w_pos = '0;
        for (int i = 0; i < N; i++) begin
            if (w_stat[i].take) begin
                w_pos = w_pos | tksi_pkg::IDX_W'(i);
                if (w_valid[i]) begin
                    w_hit = 1'b1;
                end
            end
        end
    end

    // a full list accepts only if the new score lands above the last entry
    assign w_ins_ok = w_fire && (i_item.cmd == tksi_pkg::CMD_INSERT) &&
                      (w_cap != '0) && (!w_full || w_hit);

    assign w_ctrl.insert_en = w_ins_ok;
    assign w_ctrl.score     = i_item.item_score;
    assign w_ctrl.tag       = i_item.item_tag;

    always_comb begin
        n_count  = r_count;
        n_result = '0;
        unique case (i_item.cmd)
            tksi_pkg::CMD_INSERT: begin
                if (w_ins_ok) begin
                    n_result.accepted        = 1'b1;
                    n_result.insert_position = w_pos;
                    if (!w_full) begin
                        n_count = r_count + tksi_pkg::IDX_W'(1);
                    end
                end
            end
            tksi_pkg::CMD_CLEAR: begin
                n_count = '0;
            end
            tksi_pkg::CMD_READ: begin
                if (i_item.read_index < r_count) begin
                    n_result.entry_valid = 1'b1;
                    for (int i = 0; i < N; i++) begin
                        if (i_item.read_index == tksi_pkg::IDX_W'(i)) begin
                            n_result.entry_score = w_score[i];
                            n_result.entry_tag   = w_tag[i];
                        end
                    end
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
        n_result.entry_count = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= tksi_pkg::IDX_W'(N);
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= w_fire;
            if (i_cfg_we) begin
                r_cap   <= i_cfg_wdata;
                r_count <= '0;
            end else if (w_fire) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_result <= n_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

@@ rtl/tksi_checker.sv @@
// port-level checks for the top-k sorted insert block, with its bind
module tksi_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                o_done,
    input tksi_pkg::t_out_item o_result
);

    // each transfer gives exactly one result on the next cycle
    a_done_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_done)
        else $error("no result after a command transfer");

    a_no_spurious_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |=> !o_done)
        else $error("result without a command transfer");

    a_pos_zero_on_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.accepted) |-> (o_result.insert_position == '0))
        else $error("insert position set without an accepted insert");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.entry_count <= tksi_pkg::IDX_W'(tksi_pkg::MAX_ENTRIES)))
        else $error("entry count beyond table size");

    a_read_not_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.entry_valid) |->
            (!o_result.accepted && (o_result.insert_position < o_result.entry_count ||
             o_result.insert_position == '0)))
        else $error("read result also flags an insert");

endmodule

bind top_k_sorted_insert tksi_checker u_tksi_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);
